[src/ikin_pkg.sv]
package ikin_pkg;

    localparam int COORD_BITS_DEF   = 19;
    localparam int CORDIC_STEPS_DEF = 20;

    localparam int LEN_W     = 17;
    localparam int ANKLE_W   = 16;
    localparam int FOOT_W    = 15;
    localparam int REG_IDX_W = 1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_UPPER = 1'b0,
        REG_LOWER = 1'b1
    } reg_idx_t;

    localparam logic [LEN_W-1:0] LEN_RESET = 17'd1000;

    localparam int SQRT_SHIFT = 26;
    localparam int PQ_W       = 2 * LEN_W + 2;
    localparam int RAD_W      = PQ_W + SQRT_SHIFT;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int H_W        = 2 * ROOT_W;

    localparam int VEC_W        = 64;
    localparam int NORM_STEPS   = 6;
    localparam int CORD_IN_BITS = 30;
    localparam int CORD_W       = 33;
    localparam int Z_W          = 33;
    localparam int ANG_W        = 32;

    localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    localparam int MAG_W   = ANG_W + 1;
    localparam int PROD_W  = MAG_W + 16;
    localparam int CENTI_W = 18;
    localparam logic [15:0] CENTI_PER_TURN = 16'd36000;

    localparam logic signed [CENTI_W-1:0] FOOT_MAX  = 18'sd9000;
    localparam logic signed [CENTI_W-1:0] FOOT_MIN  = -18'sd9000;
    localparam logic signed [CENTI_W-1:0] ANKLE_MAX = 18'sd18000;
    localparam logic signed [CENTI_W-1:0] ANKLE_MIN = -18'sd9000;

    typedef struct packed {
        logic unr;
        logic ay_zero;
    } side_t;

endpackage

[src/ikin_vec_angle.sv]
module ikin_vec_angle #(
    parameter int CORDIC_STEPS = ikin_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic [ikin_pkg::VEC_W-1:0]     ym,
    input  logic [ikin_pkg::VEC_W-1:0]     xm,
    input  logic                           xneg,
    output logic [ikin_pkg::ANG_W-1:0]     angle
);

    localparam int NS = ikin_pkg::NORM_STEPS;
    localparam int VW = ikin_pkg::VEC_W;
    localparam int CW = ikin_pkg::CORD_W;
    localparam int ZW = ikin_pkg::Z_W;
    localparam int AW = ikin_pkg::ANG_W;

    logic [VW-1:0] na_src [NS];
    logic [VW-1:0] nb_src [NS];
    logic [VW-1:0] na_reg [NS];
    logic [VW-1:0] nb_reg [NS];
    logic          nneg_reg [NS];

    logic signed [CW-1:0] a_reg [CORDIC_STEPS];
    logic signed [CW-1:0] b_reg [CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS];
    logic                 cneg_reg [CORDIC_STEPS];

    logic [AW-1:0] angle_reg;
    logic [AW-1:0] angle_next;
    logic [AW-1:0] z_clamp;

    // prescale so both components fit the cordic range
    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_norm
            localparam int SH = 1 << (NS - 1 - s);
            logic big;
            logic neg_src;
            if (s == 0) begin : g_first
                assign na_src[s] = xneg ? ym : xm;
                assign nb_src[s] = xneg ? xm : ym;
                assign neg_src   = xneg;
            end
            else begin : g_rest
                assign na_src[s] = na_reg[s-1];
                assign nb_src[s] = nb_reg[s-1];
                assign neg_src   = nneg_reg[s-1];
            end
            assign big = |((na_src[s] | nb_src[s]) >> (ikin_pkg::CORD_IN_BITS - 1 + SH));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    na_reg[s]   <= big ? (na_src[s] >> SH) : na_src[s];
                    nb_reg[s]   <= big ? (nb_src[s] >> SH) : nb_src[s];
                    nneg_reg[s] <= neg_src;
                end
            end
        end
    endgenerate

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
            logic signed [CW-1:0] a_src;
            logic signed [CW-1:0] b_src;
            logic signed [ZW-1:0] z_src;
            logic                 neg_src;
            logic signed [CW-1:0] da;
            logic signed [CW-1:0] db;
            logic signed [ZW-1:0] at;
            if (i == 0) begin : g_first
                assign a_src   = $signed(CW'(na_reg[NS-1][ikin_pkg::CORD_IN_BITS-1:0]));
                assign b_src   = $signed(CW'(nb_reg[NS-1][ikin_pkg::CORD_IN_BITS-1:0]));
                assign z_src   = '0;
                assign neg_src = nneg_reg[NS-1];
            end
            else begin : g_rest
                assign a_src   = a_reg[i-1];
                assign b_src   = b_reg[i-1];
                assign z_src   = z_reg[i-1];
                assign neg_src = cneg_reg[i-1];
            end
            assign da = b_src >>> i;
            assign db = a_src >>> i;
            assign at = $signed(ZW'(ikin_pkg::ATAN_TURNS[i]));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!b_src[CW-1])
                    begin
                        a_reg[i] <= a_src + da;
                        b_reg[i] <= b_src - db;
                        z_reg[i] <= z_src + at;
                    end
                    else
                    begin
                        a_reg[i] <= a_src - da;
                        b_reg[i] <= b_src + db;
                        z_reg[i] <= z_src - at;
                    end
                    cneg_reg[i] <= neg_src;
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (z_reg[CORDIC_STEPS-1] < 0)
            z_clamp = '0;
        else if (z_reg[CORDIC_STEPS-1] > $signed(ZW'(ikin_pkg::QUARTER_TURN)))
            z_clamp = ikin_pkg::QUARTER_TURN;
        else
            z_clamp = AW'(z_reg[CORDIC_STEPS-1]);
        angle_next = (cneg_reg[CORDIC_STEPS-1] ? ikin_pkg::QUARTER_TURN : '0) + z_clamp;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

[src/two_link_inverse_kinematics.sv]
// throughput: one target per cycle; the whole pipeline holds while a result waits
// the depth is mostly set by the 31 root-digit stages and the cordic iteration stages
// reset: link lengths go to 1000, all valid bits clear, payload registers keep no reset
module two_link_inverse_kinematics #(
    parameter int COORD_BITS   = ikin_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = ikin_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [ikin_pkg::REG_IDX_W-1:0]        reg_index,
    input  logic [ikin_pkg::LEN_W-1:0]            wr_data,
    input  logic                                  target_valid,
    output logic                                  target_ready,
    input  logic signed [COORD_BITS-1:0]          target_x,
    input  logic signed [COORD_BITS-1:0]          target_y,
    output logic                                  angle_valid,
    input  logic                                  angle_ready,
    output logic signed [ikin_pkg::ANKLE_W-1:0]   ankle_angle,
    output logic signed [ikin_pkg::FOOT_W-1:0]    foot_angle,
    output logic                                  unreachable
);

    localparam int CB      = COORD_BITS;
    localparam int SQ_W    = 2 * CB;
    localparam int D2_W    = 2 * CB + 1;
    localparam int LW      = ikin_pkg::LEN_W;
    localparam int PQ      = ikin_pkg::PQ_W;
    localparam int CMP_W   = (D2_W > PQ) ? D2_W : PQ;
    localparam int RW      = ikin_pkg::RAD_W + 1;
    localparam int ROOT_W  = ikin_pkg::ROOT_W;
    localparam int SS      = ikin_pkg::SQRT_SHIFT;
    localparam int VW      = ikin_pkg::VEC_W;
    localparam int AW      = ikin_pkg::ANG_W;
    localparam int MW      = ikin_pkg::MAG_W;
    localparam int PW      = ikin_pkg::PROD_W;
    localparam int CW      = ikin_pkg::CENTI_W;
    localparam int ANG_LAT = ikin_pkg::NORM_STEPS + CORDIC_STEPS + 1;
    localparam int DEPTH   = 8 + ROOT_W + ANG_LAT;

    logic adv;
    logic [DEPTH-1:0] vld_reg;

    // configuration and derived length terms
    logic [LW-1:0]     upper_len_reg;
    logic [LW-1:0]     lower_len_reg;
    logic [LW:0]       len_sum_reg;
    logic [LW-1:0]     len_dif_reg;
    logic              len_zero_reg;
    logic [2*LW-1:0]   l0sq_reg;
    logic [2*LW-1:0]   l1sq_reg;
    logic [PQ-1:0]     sum2_reg;
    logic [2*LW-1:0]   dif2_reg;
    logic [2*LW:0]     s01_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_len_reg <= ikin_pkg::LEN_RESET;
            lower_len_reg <= ikin_pkg::LEN_RESET;
        end
        else if (wr_en)
        begin
            case (ikin_pkg::reg_idx_t'(reg_index))
                ikin_pkg::REG_UPPER: upper_len_reg <= wr_data;
                ikin_pkg::REG_LOWER: lower_len_reg <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        len_sum_reg  <= {1'b0, upper_len_reg} + {1'b0, lower_len_reg};
        len_dif_reg  <= (upper_len_reg > lower_len_reg) ? upper_len_reg - lower_len_reg
                                                        : lower_len_reg - upper_len_reg;
        len_zero_reg <= (upper_len_reg == '0) || (lower_len_reg == '0);
        l0sq_reg     <= (2*LW)'(upper_len_reg) * (2*LW)'(upper_len_reg);
        l1sq_reg     <= (2*LW)'(lower_len_reg) * (2*LW)'(lower_len_reg);
        sum2_reg     <= PQ'(len_sum_reg) * PQ'(len_sum_reg);
        dif2_reg     <= (2*LW)'(len_dif_reg) * (2*LW)'(len_dif_reg);
        s01_reg      <= {1'b0, l0sq_reg} + {1'b0, l1sq_reg};
    end

    // pipeline control
    assign adv          = !vld_reg[DEPTH-1] || angle_ready;
    assign target_ready = adv;
    assign angle_valid  = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], target_valid};
    end

    // stage 1: magnitudes
    logic [CB-1:0] ax1_reg, ay1_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax1_reg <= target_x[CB-1] ? $unsigned(-target_x) : $unsigned(target_x);
            ay1_reg <= target_y[CB-1] ? $unsigned(-target_y) : $unsigned(target_y);
        end
    end

    // stage 2: squares
    logic [SQ_W-1:0] axsq2_reg, aysq2_reg;
    logic [CB-1:0]   ax2_reg, ay2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            axsq2_reg <= SQ_W'(ax1_reg) * SQ_W'(ax1_reg);
            aysq2_reg <= SQ_W'(ay1_reg) * SQ_W'(ay1_reg);
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
        end
    end

    // stage 3: squared distance
    logic [D2_W-1:0] d2_3_reg;
    logic [CB-1:0]   ax3_reg, ay3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_3_reg <= {1'b0, axsq2_reg} + {1'b0, aysq2_reg};
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
        end
    end

    // stage 4: reach test and cosine-law numerators
    logic            unr_next;
    logic [PQ-1:0]   d2r, s01e, p_next, q_next, n1m_next;
    logic [PQ:0]     t2, l1e, n2m_next;
    logic            n1neg_next, n2neg_next;

    always_comb
    begin
        unr_next   = len_zero_reg || (d2_3_reg == '0)
                     || (CMP_W'(d2_3_reg) > CMP_W'(sum2_reg))
                     || (CMP_W'(d2_3_reg) < CMP_W'(dif2_reg));
        d2r        = PQ'(d2_3_reg);
        p_next     = d2r - PQ'(dif2_reg);
        q_next     = sum2_reg - d2r;
        s01e       = PQ'(s01_reg);
        n1neg_next = d2r > s01e;
        n1m_next   = n1neg_next ? d2r - s01e : s01e - d2r;
        t2         = {1'b0, d2r} + (PQ+1)'(l0sq_reg);
        l1e        = (PQ+1)'(l1sq_reg);
        n2neg_next = l1e > t2;
        n2m_next   = n2neg_next ? l1e - t2 : t2 - l1e;
    end

    // square roots, one result bit per stage; element 0 is stage 4
    logic [RW-1:0]     prem_reg  [ROOT_W+1];
    logic [RW-1:0]     qrem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] proot_reg [ROOT_W+1];
    logic [ROOT_W-1:0] qroot_reg [ROOT_W+1];
    logic              cunr_reg  [ROOT_W+1];
    logic              cn1neg_reg [ROOT_W+1];
    logic              cn2neg_reg [ROOT_W+1];
    logic [PQ-1:0]     cn1m_reg  [ROOT_W+1];
    logic [PQ:0]       cn2m_reg  [ROOT_W+1];
    logic [CB-1:0]     cax_reg   [ROOT_W+1];
    logic [CB-1:0]     cay_reg   [ROOT_W+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prem_reg[0]   <= RW'({p_next, {SS{1'b0}}});
            qrem_reg[0]   <= RW'({q_next, {SS{1'b0}}});
            proot_reg[0]  <= '0;
            qroot_reg[0]  <= '0;
            cunr_reg[0]   <= unr_next;
            cn1neg_reg[0] <= n1neg_next;
            cn2neg_reg[0] <= n2neg_next;
            cn1m_reg[0]   <= n1m_next;
            cn2m_reg[0]   <= n2m_next;
            cax_reg[0]    <= ax3_reg;
            cay_reg[0]    <= ay3_reg;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= ROOT_W; k++) begin : g_sqrt
            localparam int B = ROOT_W - k;
            logic [RW-1:0] pt, qt;
            logic          ptake, qtake;
            assign pt    = (RW'(proot_reg[k-1]) << (B + 1)) | (RW'(1) << (2 * B));
            assign qt    = (RW'(qroot_reg[k-1]) << (B + 1)) | (RW'(1) << (2 * B));
            assign ptake = prem_reg[k-1] >= pt;
            assign qtake = qrem_reg[k-1] >= qt;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prem_reg[k]   <= ptake ? prem_reg[k-1] - pt : prem_reg[k-1];
                    qrem_reg[k]   <= qtake ? qrem_reg[k-1] - qt : qrem_reg[k-1];
                    proot_reg[k]  <= proot_reg[k-1] | (ROOT_W'(ptake) << B);
                    qroot_reg[k]  <= qroot_reg[k-1] | (ROOT_W'(qtake) << B);
                    cunr_reg[k]   <= cunr_reg[k-1];
                    cn1neg_reg[k] <= cn1neg_reg[k-1];
                    cn2neg_reg[k] <= cn2neg_reg[k-1];
                    cn1m_reg[k]   <= cn1m_reg[k-1];
                    cn2m_reg[k]   <= cn2m_reg[k-1];
                    cax_reg[k]    <= cax_reg[k-1];
                    cay_reg[k]    <= cay_reg[k-1];
                end
            end
        end
    endgenerate

    // triangle height
    logic [ikin_pkg::H_W-1:0] h_reg;
    logic                     hunr_reg, hn1neg_reg, hn2neg_reg;
    logic [PQ-1:0]            hn1m_reg;
    logic [PQ:0]              hn2m_reg;
    logic [CB-1:0]            hax_reg, hay_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg      <= ikin_pkg::H_W'(proot_reg[ROOT_W]) * ikin_pkg::H_W'(qroot_reg[ROOT_W]);
            hunr_reg   <= cunr_reg[ROOT_W];
            hn1neg_reg <= cn1neg_reg[ROOT_W];
            hn2neg_reg <= cn2neg_reg[ROOT_W];
            hn1m_reg   <= cn1m_reg[ROOT_W];
            hn2m_reg   <= cn2m_reg[ROOT_W];
            hax_reg    <= cax_reg[ROOT_W];
            hay_reg    <= cay_reg[ROOT_W];
        end
    end

    // three angle units in parallel
    logic [AW-1:0] a1, a2, a3;

    ikin_vec_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_foot_acos (
        .clk   (clk),
        .en    (adv),
        .ym    (VW'(h_reg)),
        .xm    (VW'({hn1m_reg, {SS{1'b0}}})),
        .xneg  (hn1neg_reg),
        .angle (a1)
    );

    ikin_vec_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_ankle_acos (
        .clk   (clk),
        .en    (adv),
        .ym    (VW'(h_reg)),
        .xm    (VW'({hn2m_reg, {SS{1'b0}}})),
        .xneg  (hn2neg_reg),
        .angle (a2)
    );

    ikin_vec_angle #(.CORDIC_STEPS(CORDIC_STEPS)) u_ankle_atan (
        .clk   (clk),
        .en    (adv),
        .ym    (VW'(hax_reg)),
        .xm    (VW'(hay_reg)),
        .xneg  (1'b0),
        .angle (a3)
    );

    ikin_pkg::side_t side_reg [ANG_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].unr     <= hunr_reg;
            side_reg[0].ay_zero <= (hay_reg == '0);
        end
    end

    genvar j;
    generate
        for (j = 1; j < ANG_LAT; j++) begin : g_side
            always_ff @(posedge clk)
            begin
                if (adv)
                    side_reg[j] <= side_reg[j-1];
            end
        end
    endgenerate

    // angle to centidegrees: magnitude, scale, sign and clamp, zeroed when unreachable
    logic [AW-1:0]        a3s;
    logic signed [AW+1:0] v1, v2;
    logic [MW-1:0]        m1_reg, m2_reg;
    logic                 neg1_reg, neg2_reg, funr_reg;

    always_comb
    begin
        a3s = side_reg[ANG_LAT-1].ay_zero ? ikin_pkg::QUARTER_TURN : a3;
        v1  = $signed({2'b0, a1}) - $signed({2'b0, ikin_pkg::QUARTER_TURN});
        v2  = $signed({2'b0, a2}) + $signed({2'b0, a3s})
              - $signed({2'b0, ikin_pkg::QUARTER_TURN});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg   <= v1[AW+1] ? MW'($unsigned(-v1)) : MW'($unsigned(v1));
            m2_reg   <= v2[AW+1] ? MW'($unsigned(-v2)) : MW'($unsigned(v2));
            neg1_reg <= v1[AW+1];
            neg2_reg <= v2[AW+1];
            funr_reg <= side_reg[ANG_LAT-1].unr;
        end
    end

    logic [PW-1:0] p1, p2;
    logic [PW-33:0] r1_reg, r2_reg;
    logic           rneg1_reg, rneg2_reg, runr_reg;

    assign p1 = PW'(m1_reg) * PW'(ikin_pkg::CENTI_PER_TURN) + (PW'(1) << 31);
    assign p2 = PW'(m2_reg) * PW'(ikin_pkg::CENTI_PER_TURN) + (PW'(1) << 31);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg    <= p1[PW-1:32];
            r2_reg    <= p2[PW-1:32];
            rneg1_reg <= neg1_reg;
            rneg2_reg <= neg2_reg;
            runr_reg  <= funr_reg;
        end
    end

    logic signed [CW-1:0] sf, sa, cf, ca;
    logic signed [ikin_pkg::ANKLE_W-1:0] ankle_reg, ankle_next;
    logic signed [ikin_pkg::FOOT_W-1:0]  foot_reg, foot_next;
    logic                                unr_reg;

    always_comb
    begin
        sf = rneg1_reg ? -$signed(CW'(r1_reg)) : $signed(CW'(r1_reg));
        sa = rneg2_reg ? -$signed(CW'(r2_reg)) : $signed(CW'(r2_reg));
        if (sf > ikin_pkg::FOOT_MAX)
            cf = ikin_pkg::FOOT_MAX;
        else if (sf < ikin_pkg::FOOT_MIN)
            cf = ikin_pkg::FOOT_MIN;
        else
            cf = sf;
        if (sa > ikin_pkg::ANKLE_MAX)
            ca = ikin_pkg::ANKLE_MAX;
        else if (sa < ikin_pkg::ANKLE_MIN)
            ca = ikin_pkg::ANKLE_MIN;
        else
            ca = sa;
        foot_next  = runr_reg ? '0 : ikin_pkg::FOOT_W'(cf);
        ankle_next = runr_reg ? '0 : ikin_pkg::ANKLE_W'(ca);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ankle_reg <= ankle_next;
            foot_reg  <= foot_next;
            unr_reg   <= runr_reg;
        end
    end

    assign ankle_angle = ankle_reg;
    assign foot_angle  = foot_reg;
    assign unreachable = unr_reg;

    a_unr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && unreachable |-> ankle_angle == '0 && foot_angle == '0)
        else $error("unreachable beat with nonzero angles");

    a_foot_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> foot_angle >= 15'sd0 - 15'sd9000 && foot_angle <= 15'sd9000)
        else $error("foot angle out of range");

    a_ankle_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> ankle_angle >= 16'sd0 - 16'sd9000 && ankle_angle <= 16'sd18000)
        else $error("ankle angle out of range");

    a_acos_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DEPTH-4] |-> a1 <= 32'h8000_0000 && a2 <= 32'h8000_0000
                             && a3 <= ikin_pkg::QUARTER_TURN)
        else $error("cordic angle beyond half turn");

endmodule
